FILE: hdl/arpc_pkg.sv
// shared types and constants for the arp cache with aging
// used by arpc_cell and arp_cache_with_aging_core; no dependencies
`default_nettype none

package arpc_pkg;

    localparam int ENTRIES_DEF = 8;
    // wide enough to hold the largest entry count, 64
    localparam int IDX_W = 7;

    typedef logic [IDX_W-1:0] arpc_idx_t;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_LEARN  = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NOP    = 2'd3
    } arpc_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } arpc_state_t;

    localparam logic [1:0] REG_SUBNET_MASK = 2'd0;
    localparam logic [1:0] REG_GATEWAY     = 2'd1;
    localparam logic [1:0] REG_LIFETIME    = 2'd2;

    // request token walking the row of cells
    typedef struct packed {
        logic      active;
        arpc_op_t  op;
        logic [31:0] addr;
        logic [47:0] mac;
        logic      hit;
        arpc_idx_t hit_idx;
        logic      free_ok;
        arpc_idx_t free_idx;
        logic [47:0] mac_res;
    } arpc_tok_t;

    // write broadcast issued once the walk of a learn is done
    typedef struct packed {
        logic      we;
        logic      fill;
        arpc_idx_t idx;
        logic [31:0] addr;
        logic [47:0] mac;
        logic [7:0]  age;
    } arpc_wr_t;

endpackage

`default_nettype wire

FILE: hdl/arp_cache_with_aging_core.sv
// arp cache with aging: request control, configuration registers and row of cells
// depends on arpc_pkg and arpc_cell
//
// usage:
//   s_ channel carries one request: tuser holds the opcode (tick, learn,
//   lookup, no-op), tdata the ipv4 address and the mac address to learn.
//   m_ channel returns exactly one result per request: found, entry index
//   (ENTRIES when nothing matched), mac of the matched entry and a drop flag
//   for a learn that found neither a match nor a free entry.
//   cfg_ channel writes subnet mask, gateway address and entry lifetime;
//   cfg_ready is always high, writes are meant for an idle block.
// timing:
//   a request walks the row of ENTRIES cells one cell per cycle, the first
//   cell in the accept cycle; the token leaving the last cell is registered
//   in res_reg, then the finish state, once the output register is free,
//   writes back a learn and loads the result; one request at a time.
//   s_tready is high whenever no request is in flight, even while a result
//   still waits in the output register.
// reset: all entries free with age zero, registers at their reset values.
// stall: a held result keeps the next request waiting at the end of its walk.
`default_nettype none

module arp_cache_with_aging_core #(
    parameter int ENTRIES = arpc_pkg::ENTRIES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [31:0] ip_address, [79:32] mac_address
    input  wire logic [79:0] s_tdata,
    // [1:0] opcode
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [0] found, [4:1] entry_index, [52:5] mac_result, [53] dropped, [55:54] zero
    output logic [55:0]      m_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import arpc_pkg::*;

    localparam arpc_idx_t NONE_IDX = IDX_W'(ENTRIES);

    logic [31:0] mask_reg;
    logic [31:0] gw_reg;
    logic [7:0]  life_reg;

    arpc_state_t state_reg, state_next;
    arpc_tok_t   head_tok;
    arpc_tok_t   tok [ENTRIES+1];
    arpc_tok_t   res_reg;
    arpc_wr_t    wr;

    logic        s_accept;
    logic        out_load;
    logic        m_valid_reg, m_valid_next;
    logic [55:0] m_data_reg, m_data_next;
    arpc_op_t    in_op;
    logic [31:0] in_ip;
    logic        res_found;
    logic        res_drop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= 32'hFFFF_FF00;
            gw_reg   <= 32'd0;
            life_reg <= 8'd254;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_SUBNET_MASK: mask_reg <= cfg_data;
                REG_GATEWAY:     gw_reg   <= cfg_data;
                REG_LIFETIME:    life_reg <= cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    assign in_op    = arpc_op_t'(s_tuser);
    assign in_ip    = s_tdata[31:0];
    assign s_accept = s_tvalid && s_tready;

    // head token, off-subnet lookups go to the gateway
    always_comb begin
        head_tok        = '0;
        head_tok.active = s_accept;
        head_tok.op     = in_op;
        head_tok.addr   = in_ip;
        head_tok.mac    = s_tdata[79:32];
        if ((in_op == OP_LOOKUP) && ((in_ip & mask_reg) != (gw_reg & mask_reg))) begin
            head_tok.addr = gw_reg;
        end
    end

    assign tok[0] = head_tok;

    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        arpc_cell #(
            .CELL_ID (i)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tok_in  (tok[i]),
            .wr      (wr),
            .tok_out (tok[i+1])
        );
    end

    assign res_found = (res_reg.op == OP_LOOKUP) && res_reg.hit;
    assign res_drop  = (res_reg.op == OP_LEARN) && (res_reg.addr != 32'd0)
                       && !res_reg.hit && !res_reg.free_ok;

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (tok[ENTRIES].active) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // learn write-back: refresh the match, else fill the first free entry
    always_comb begin
        wr.we   = out_load && (res_reg.op == OP_LEARN) && (res_reg.addr != 32'd0)
                  && (res_reg.hit || res_reg.free_ok);
        wr.fill = !res_reg.hit;
        wr.idx  = res_reg.hit ? res_reg.hit_idx : res_reg.free_idx;
        wr.addr = res_reg.addr;
        wr.mac  = res_reg.mac;
        wr.age  = life_reg;
    end

    always_comb begin
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (out_load) begin
            m_valid_next      = 1'b1;
            m_data_next       = '0;
            m_data_next[0]    = res_found;
            m_data_next[4:1]  = res_found ? res_reg.hit_idx[3:0] : NONE_IDX[3:0];
            m_data_next[52:5] = res_found ? res_reg.mac_res : 48'd0;
            m_data_next[53]   = res_drop;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (tok[ENTRIES].active) begin
            res_reg <= tok[ENTRIES];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    a_accept_starts_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == ST_WALK))
        else $error("accepted request did not start a walk");

    a_tail_only_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        tok[ENTRIES].active |-> (state_reg == ST_WALK))
        else $error("token left the row outside a walk");

    a_hit_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_FINISH) && res_reg.hit) |-> (res_reg.hit_idx < NONE_IDX))
        else $error("hit index beyond the table");

    a_write_only_learn: assert property (@(posedge aclk) disable iff (!aresetn)
        wr.we |-> ((res_reg.op == OP_LEARN) && (state_reg == ST_FINISH)))
        else $error("entry write outside a learn");

    a_load_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (m_tvalid && !(m_tdata[0] && m_tdata[53])))
        else $error("result load lost or both found and dropped");
`endif

endmodule

`default_nettype wire

FILE: hdl/arpc_cell.sv
// one cache entry: address, mac and age, plus the token stage in front of it
// depends on arpc_pkg
`default_nettype none

module arpc_cell #(
    parameter int CELL_ID = 0
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire arpc_pkg::arpc_tok_t tok_in,
    input  wire arpc_pkg::arpc_wr_t  wr,
    output arpc_pkg::arpc_tok_t    tok_out
);
    import arpc_pkg::*;

    logic [31:0] ip_reg, ip_next;
    logic [7:0]  age_reg, age_next;
    logic [47:0] mac_reg, mac_next;
    arpc_tok_t   tok_reg, tok_next;
    logic        occupied;
    logic        match;
    logic        wr_sel;

    assign occupied = (ip_reg != 32'd0);
    assign match    = (tok_in.addr != 32'd0) && (ip_reg == tok_in.addr);
    assign wr_sel   = wr.we && (wr.idx == IDX_W'(CELL_ID));

    always_comb begin
        tok_next = tok_in;
        ip_next  = ip_reg;
        age_next = age_reg;
        mac_next = mac_reg;
        if (tok_in.active) begin
            unique case (tok_in.op)
                OP_TICK: begin
                    if (occupied) begin
                        if (age_reg == 8'd0) begin
                            ip_next = 32'd0;
                        end else begin
                            age_next = age_reg - 8'd1;
                        end
                    end
                end
                OP_LEARN: begin
                    if (match && !tok_in.hit) begin
                        tok_next.hit     = 1'b1;
                        tok_next.hit_idx = IDX_W'(CELL_ID);
                    end
                    if (!occupied && !tok_in.free_ok) begin
                        tok_next.free_ok  = 1'b1;
                        tok_next.free_idx = IDX_W'(CELL_ID);
                    end
                end
                OP_LOOKUP: begin
                    if (match && !tok_in.hit) begin
                        tok_next.hit     = 1'b1;
                        tok_next.hit_idx = IDX_W'(CELL_ID);
                        tok_next.mac_res = mac_reg;
                    end
                end
                OP_NOP: begin
                end
            endcase
        end
        if (wr_sel) begin
            age_next = wr.age;
            if (wr.fill) begin
                ip_next  = wr.addr;
                mac_next = wr.mac;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ip_reg  <= 32'd0;
            age_reg <= 8'd0;
            tok_reg <= '0;
        end else begin
            ip_reg  <= ip_next;
            age_reg <= age_next;
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        mac_reg <= mac_next;
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

FILE: tb/sv/arp_cache_with_aging_core_tb.sv
`timescale 1ns / 1ps
// testbench for arp_cache_with_aging_core: shadow arp table predicts every result,
// random requests with idle bursts on both streams; depends on arpc_pkg and the core

module arp_cache_with_aging_core_tb;
    import arpc_pkg::*;

    localparam int N_ENTRIES = ENTRIES_DEF;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic        dropped;
        logic [47:0] mac_result;
        logic [3:0]  entry_index;
        logic        found;
    } arp_result_t;

    // shadow copy of the cache, its registers and the results still owed
    class arp_cache_shadow;
        logic [31:0] subnet_mask;
        logic [31:0] gateway;
        logic [7:0]  lifetime;
        logic [31:0] slot_ip[N_ENTRIES];
        logic [47:0] slot_mac[N_ENTRIES];
        logic [7:0]  slot_age[N_ENTRIES];
        arp_result_t pending_results[$];
        int          errors;

        function new();
            subnet_mask = 32'hFFFF_FF00;
            gateway = 32'h0;
            lifetime = 8'd254;
            errors = 0;
            for (int i = 0; i < N_ENTRIES; i++) begin
                slot_ip[i] = 32'h0;
                slot_mac[i] = 48'h0;
                slot_age[i] = 8'h0;
            end
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_SUBNET_MASK: subnet_mask = val;
                REG_GATEWAY:     gateway = val;
                REG_LIFETIME:    lifetime = val[7:0];
                default: ;
            endcase
        endfunction

        function arp_result_t resolve_request(arpc_op_t op, logic [31:0] ip, logic [47:0] mac);
            arp_result_t res;
            logic [31:0] target;
            bit done;
            res = '0;
            res.entry_index = 4'(N_ENTRIES);
            done = 0;
            case (op)
                OP_TICK: begin
                    for (int i = 0; i < N_ENTRIES; i++) begin
                        if (slot_ip[i] != 0) begin
                            if (slot_age[i] == 8'd0) slot_ip[i] = 32'h0;
                            else slot_age[i] = slot_age[i] - 8'd1;
                        end
                    end
                end
                OP_LEARN: begin
                    // address zero marks a free slot, so it is never stored
                    if (ip != 0) begin
                        for (int i = 0; i < N_ENTRIES && !done; i++) begin
                            if (slot_ip[i] == ip) begin
                                slot_age[i] = lifetime;
                                done = 1;
                            end
                        end
                        for (int i = 0; i < N_ENTRIES && !done; i++) begin
                            if (slot_ip[i] == 0) begin
                                slot_ip[i] = ip;
                                slot_mac[i] = mac;
                                slot_age[i] = lifetime;
                                done = 1;
                            end
                        end
                        res.dropped = !done;
                    end
                end
                OP_LOOKUP: begin
                    target = ip;
                    if ((ip & subnet_mask) != (gateway & subnet_mask)) target = gateway;
                    if (target != 0) begin
                        for (int i = 0; i < N_ENTRIES && !done; i++) begin
                            if (slot_ip[i] == target) begin
                                res.found = 1'b1;
                                res.entry_index = 4'(i);
                                res.mac_result = slot_mac[i];
                                done = 1;
                            end
                        end
                    end
                end
                default: ;
            endcase
            return res;
        endfunction

        function void note_request(arpc_op_t op, logic [31:0] ip, logic [47:0] mac);
            pending_results.push_back(resolve_request(op, ip, mac));
        endfunction

        function void check_result(logic [55:0] word);
            arp_result_t got;
            arp_result_t want;
            got = arp_result_t'(word[53:0]);
            if (pending_results.size() == 0) begin
                $error("result with no request waiting: %h", word);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.found !== want.found) begin
                $error("found: expected %0d, got %0d", want.found, got.found);
                errors++;
            end
            if (got.entry_index !== want.entry_index) begin
                $error("entry_index: expected %0d, got %0d", want.entry_index, got.entry_index);
                errors++;
            end
            if (got.mac_result !== want.mac_result) begin
                $error("mac_result: expected %h, got %h", want.mac_result, got.mac_result);
                errors++;
            end
            if (got.dropped !== want.dropped) begin
                $error("dropped: expected %0d, got %0d", want.dropped, got.dropped);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    arp_cache_shadow sb;
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    bit rx_long_req = 1'b0;
    int cycles = 0;

    arp_cache_with_aging_core #(
        .ENTRIES(N_ENTRIES)
    ) u_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // result side: random stall bursts, plus one long hold-off on request
    initial begin
        int stall;
        stall = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_long_req) begin
                rx_long_req = 1'b0;
                stall = 400;
            end else if (stall == 0 && rx_idle_en && $urandom_range(0, 9) == 0) begin
                stall = $urandom_range(1, 9);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic logic [47:0] rand_mac();
        return 48'({$urandom, $urandom});
    endfunction

    // valid stays high between back-to-back requests
    task automatic push_request(arpc_op_t op, logic [31:0] ip, logic [47:0] mac);
        int gap;
        @(negedge aclk);
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 9);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {mac, ip};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(op, ip, mac);
    endtask

    // drop valid and let every owed result drain
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (N_ENTRIES + 3) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(logic [31:0] mask, logic [31:0] gw, logic [7:0] life);
        drain();
        write_reg(REG_SUBNET_MASK, mask);
        write_reg(REG_GATEWAY, gw);
        write_reg(REG_LIFETIME, {24'h0, life});
    endtask

    // mostly learns and lookups on a small set of on-subnet hosts, some noise
    task automatic run_traffic(int count, int pool_n, int tick_w);
        arpc_op_t    op;
        logic [31:0] ip;
        logic [31:0] host;
        int          r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                op = arpc_op_t'(2'($urandom_range(0, 3)));
                ip = $urandom;
            end else begin
                r = $urandom_range(0, 99);
                if (r < tick_w) op = OP_TICK;
                else if (r < tick_w + 38) op = OP_LEARN;
                else if (r < 97) op = OP_LOOKUP;
                else op = OP_NOP;
                r = $urandom_range(0, 99);
                host = 32'($urandom_range(1, pool_n));
                if (r < 75) begin
                    ip = (sb.gateway & sb.subnet_mask) | (host & ~sb.subnet_mask);
                    if (ip == 0) ip = host;
                end else if (r < 85) begin
                    ip = sb.gateway;
                end else if (r < 96) begin
                    ip = $urandom;
                end else begin
                    ip = 32'h0;
                end
            end
            push_request(op, ip, rand_mac());
        end
    endtask

    initial begin
        sb = new();
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_NOP;
        cfg_valid = 1'b0;
        cfg_index = REG_SUBNET_MASK;
        cfg_data = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty table, zero address, refresh, full table, aging
        push_request(OP_LOOKUP, 32'h0, 48'h0);
        push_request(OP_TICK, 32'h0, 48'h0);
        push_request(OP_NOP, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        push_request(OP_LEARN, 32'h0, 48'hFFFF_FFFF_FFFF);
        push_request(OP_LEARN, 32'h1, 48'hFFFF_FFFF_FFFF);
        push_request(OP_LEARN, 32'hFF, 48'h0);
        push_request(OP_LEARN, 32'h1, 48'h0000_0000_0123);
        push_request(OP_LOOKUP, 32'h1, 48'h0);
        push_request(OP_LOOKUP, 32'hFFFF_FFFF, 48'h0);
        for (int i = 2; i < 8; i++) push_request(OP_LEARN, 32'(i), rand_mac());
        push_request(OP_LEARN, 32'h80, 48'hAAAA_5555_AAAA);
        push_request(OP_LOOKUP, 32'hFF, 48'h0);
        push_request(OP_LOOKUP, 32'h7, 48'h0);
        push_request(OP_TICK, 32'h0, 48'h0);
        push_request(OP_LOOKUP, 32'h3, 48'hFFFF_FFFF_FFFF);
        push_request(OP_NOP, 32'h1, 48'h0);

        configure(32'hFFFF_FF00, 32'h0A00_0001, 8'd254);
        run_traffic(300, 10, 10);
        configure(32'hFFFF_0000, 32'hC0A8_0101, 8'd3);
        run_traffic(300, 12, 25);
        configure(32'h0, 32'hFFFF_FFFF, 8'd1);
        run_traffic(200, 10, 15);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        configure(32'hFFFF_FFFF, $urandom | 32'h1, 8'd0);
        run_traffic(150, 6, 20);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        configure(32'hFFFF_FFF0, 32'h0, 8'd255);
        rx_long_req = 1'b1;
        run_traffic(300, 14, 15);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        configure(32'hFFFF_FF00, $urandom, 8'd5);
        run_traffic(200, 9, 20);

        drain();
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
